/* design/bertlv_pkg.sv */
// Shared types and constants for the BER integer TLV encoder.
package bertlv_pkg;

   localparam int TAG_W  = 8;
   localparam int ROOM_W = 16;
   localparam int LEN_W  = 4;
   localparam int BYTE_W = 8;

   localparam logic OP_SIGNED   = 1'b0;
   localparam logic OP_UNSIGNED = 1'b1;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  clen;
      logic [LEN_W-1:0]  ndata;
      logic              pad;
      logic              err;
      logic [ROOM_W-1:0] room;
   } bertlv_ctrl_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TAG,
      PH_LEN,
      PH_PAD,
      PH_DATA,
      PH_ERR
   } bertlv_phase_type;

endpackage

/* design/bertlv_front.sv */
// Front end: sizes the content, checks buffer room and left-aligns the value.
module bertlv_front #(
   parameter int VALUE_BYTES = 8
) (
   input  logic                                 opcode,
   input  logic [bertlv_pkg::TAG_W-1:0]         tag,
   input  logic signed [63:0]                   value,
   input  logic [bertlv_pkg::ROOM_W-1:0]        room,
   output bertlv_pkg::bertlv_ctrl_type          ctrl,
   output logic [VALUE_BYTES*8-1:0]             content
);

   localparam int VW = VALUE_BYTES * 8;

   logic [VW-1:0]                   v;
   logic [VW-1:0]                   diff;
   logic [VW-1:0]                   mask;
   logic                            pad;
   logic [bertlv_pkg::LEN_W-1:0]    strip;
   logic [bertlv_pkg::LEN_W-1:0]    len;
   logic [bertlv_pkg::LEN_W-1:0]    clen;

   assign v    = value[VW-1:0];
   assign diff = v ^ {VW{v[VW-1]}};
   assign pad  = (opcode == bertlv_pkg::OP_UNSIGNED) && v[VW-1];

   always_comb begin
      strip = '0;
      mask  = '0;
      if (!pad) begin
         for (int j = 1; j < VALUE_BYTES; j++) begin
            mask = {VW{1'b1}} << (VW - 8 * j - 1);
            if ((diff & mask) == '0) begin
               strip = bertlv_pkg::LEN_W'(j);
            end
         end
      end
   end

   assign len  = bertlv_pkg::LEN_W'(VALUE_BYTES) - strip;
   assign clen = len + {{(bertlv_pkg::LEN_W-1){1'b0}}, pad};

   assign content    = v << {strip, 3'b000};
   assign ctrl.tag   = tag;
   assign ctrl.clen  = clen;
   assign ctrl.ndata = len;
   assign ctrl.pad   = pad;
   assign ctrl.err   = room < (bertlv_pkg::ROOM_W'(clen) + bertlv_pkg::ROOM_W'(2));
   assign ctrl.room  = room;

endmodule

/* design/bertlv_queue.sv */
// Two-entry request queue between the front end and the byte sequencer.
module bertlv_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign nonempty = (count_ff != 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign rdata    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* design/bertlv_back.sv */
// Back end: emits tag, length, pad and content bytes, or an error byte, into the output register.
module bertlv_back #(
   parameter int VALUE_BYTES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_nonempty,
   input  bertlv_pkg::bertlv_ctrl_type        q_ctrl,
   input  logic [VALUE_BYTES*8-1:0]           q_content,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bertlv_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                               rsp_last,
   output logic                               rsp_error,
   output logic [bertlv_pkg::ROOM_W-1:0]      rsp_room_left
);

   localparam int VW = VALUE_BYTES * 8;

   bertlv_pkg::bertlv_phase_type  phase_ff, phase_in;
   bertlv_pkg::bertlv_ctrl_type   ent_ff, ent_in;
   logic [VW-1:0]                 content_ff, content_in;
   logic [bertlv_pkg::LEN_W-1:0]  remain_ff, remain_in;
   logic [bertlv_pkg::ROOM_W-1:0] left_ff, left_in;

   logic                          valid_ff, valid_in;
   logic [bertlv_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                          last_ff, last_in;
   logic                          err_ff, err_in;
   logic [bertlv_pkg::ROOM_W-1:0] rleft_ff, rleft_in;

   logic                          adv;
   logic                          emit;
   logic                          done;
   logic                          load;
   logic [bertlv_pkg::BYTE_W-1:0] cur_byte;
   logic                          cur_last;
   logic                          cur_err;
   logic [bertlv_pkg::ROOM_W-1:0] cur_left;

   assign adv  = !valid_ff || !rsp_stall;
   assign emit = adv && (phase_ff != bertlv_pkg::PH_IDLE);

   always_comb begin
      cur_byte = '0;
      cur_last = 1'b0;
      cur_err  = 1'b0;
      cur_left = left_ff - bertlv_pkg::ROOM_W'(1);
      unique case (phase_ff)
         bertlv_pkg::PH_TAG: begin
            cur_byte = ent_ff.tag;
         end
         bertlv_pkg::PH_LEN: begin
            cur_byte = bertlv_pkg::BYTE_W'(ent_ff.clen);
         end
         bertlv_pkg::PH_PAD: begin
            cur_byte = '0;
         end
         bertlv_pkg::PH_DATA: begin
            cur_byte = content_ff[VW-1 -: bertlv_pkg::BYTE_W];
            cur_last = (remain_ff == bertlv_pkg::LEN_W'(1));
         end
         bertlv_pkg::PH_ERR: begin
            cur_last = 1'b1;
            cur_err  = 1'b1;
            cur_left = left_ff;
         end
         default: begin
            cur_byte = '0;
         end
      endcase
   end

   assign done  = emit && cur_last;
   assign load  = ((phase_ff == bertlv_pkg::PH_IDLE) || done) && q_nonempty;
   assign q_pop = load;

   always_comb begin
      phase_in   = phase_ff;
      ent_in     = ent_ff;
      content_in = content_ff;
      remain_in  = remain_ff;
      left_in    = left_ff;
      if (load) begin
         ent_in     = q_ctrl;
         content_in = q_content;
         remain_in  = q_ctrl.ndata;
         left_in    = q_ctrl.room;
         phase_in   = q_ctrl.err ? bertlv_pkg::PH_ERR : bertlv_pkg::PH_TAG;
      end else if (done) begin
         phase_in = bertlv_pkg::PH_IDLE;
      end else if (emit) begin
         left_in = cur_left;
         unique case (phase_ff)
            bertlv_pkg::PH_TAG: begin
               phase_in = bertlv_pkg::PH_LEN;
            end
            bertlv_pkg::PH_LEN: begin
               phase_in = ent_ff.pad ? bertlv_pkg::PH_PAD : bertlv_pkg::PH_DATA;
            end
            bertlv_pkg::PH_PAD: begin
               phase_in = bertlv_pkg::PH_DATA;
            end
            bertlv_pkg::PH_DATA: begin
               content_in = content_ff << bertlv_pkg::BYTE_W;
               remain_in  = remain_ff - bertlv_pkg::LEN_W'(1);
            end
            default: begin
               phase_in = bertlv_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      rleft_in = rleft_ff;
      if (adv) begin
         valid_in = emit;
      end
      if (emit) begin
         byte_in  = cur_byte;
         last_in  = cur_last;
         err_in   = cur_err;
         rleft_in = cur_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bertlv_pkg::PH_IDLE;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff     <= ent_in;
      content_ff <= content_in;
      remain_ff  <= remain_in;
      left_ff    <= left_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      err_ff     <= err_in;
      rleft_ff   <= rleft_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last      = last_ff;
   assign rsp_error     = err_ff;
   assign rsp_room_left = rleft_ff;

endmodule

/* design/ber_integer_tlv_encoder.sv */
// Top level of the BER integer TLV encoder.
// A request passes through the queue, the sequencer state and the output register before its first byte is on rsp.
// Throughput: one byte per cycle from the back-end sequencer while rsp_stall is low; a request
// gives 2 + content length bytes (3 to VALUE_BYTES + 3), or one error byte when room is short.
// The two-entry queue takes new requests while the sequencer is still emitting.
// Reset: synchronous, active high; clears the queue, the sequencer and rsp_valid.
module ber_integer_tlv_encoder #(
   parameter int VALUE_BYTES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [bertlv_pkg::TAG_W-1:0]   req_tag,
   input  logic signed [63:0]             req_value,
   input  logic [bertlv_pkg::ROOM_W-1:0]  req_room,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bertlv_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                           rsp_last,
   output logic                           rsp_error,
   output logic [bertlv_pkg::ROOM_W-1:0]  rsp_room_left
);

   localparam int VW    = VALUE_BYTES * 8;
   localparam int QW    = $bits(bertlv_pkg::bertlv_ctrl_type) + VW;

   bertlv_pkg::bertlv_ctrl_type f_ctrl;
   logic [VW-1:0]               f_content;
   bertlv_pkg::bertlv_ctrl_type q_ctrl;
   logic [VW-1:0]               q_content;
   logic [QW-1:0]               q_wdata;
   logic [QW-1:0]               q_rdata;
   logic                        q_full;
   logic                        q_nonempty;
   logic                        q_pop;

   bertlv_front #(
      .VALUE_BYTES (VALUE_BYTES)
   ) u_front (
      .opcode  (req_opcode),
      .tag     (req_tag),
      .value   (req_value),
      .room    (req_room),
      .ctrl    (f_ctrl),
      .content (f_content)
   );

   assign q_wdata   = {f_ctrl, f_content};
   assign req_stall = q_full;

   bertlv_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid),
      .wdata    (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .nonempty (q_nonempty),
      .rdata    (q_rdata)
   );

   assign {q_ctrl, q_content} = q_rdata;

   bertlv_back #(
      .VALUE_BYTES (VALUE_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_nonempty    (q_nonempty),
      .q_ctrl        (q_ctrl),
      .q_content     (q_content),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .rsp_error     (rsp_error),
      .rsp_room_left (rsp_room_left)
   );

endmodule

/* design/bertlv_checker.sv */
// Port-level assertions for the BER integer TLV encoder, bound to the top level.
module bertlv_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [bertlv_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic                           rsp_last,
   input logic                           rsp_error,
   input logic [bertlv_pkg::ROOM_W-1:0]  rsp_room_left
);

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last)
      else $error("error response without last");

   a_err_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_out_byte == '0)
      else $error("error response carries a byte");

   a_room_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && !rsp_error &&
         rsp_room_left == $past(rsp_room_left) - bertlv_pkg::ROOM_W'(1))
      else $error("room_left did not step down by one within an encoding");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled response changed");

endmodule

bind ber_integer_tlv_encoder bertlv_checker u_bertlv_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the BER integer TLV encoder.
module testbench;
   import bertlv_pkg::*;

   localparam int VALUE_BYTES    = 8;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int RANDOM_ITEMS   = 70;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
      logic              error;
      logic [ROOM_W-1:0] room_left;
   } tlv_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_opcode = 1'b0;
   logic [TAG_W-1:0]  req_tag = '0;
   logic [63:0]       req_value = '0;
   logic [ROOM_W-1:0] req_room = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last;
   logic              rsp_error;
   logic [ROOM_W-1:0] rsp_room_left;

   tlv_byte_type pending_bytes[$];
   int        mismatches = 0;
   int        cycle_count = 0;
   int        holdoff_asked = 0;
   int        holdoff_served = 0;
   int        hold_left = 0;
   int        run_left = 0;
   logic      run_stalls = 1'b0;

   ber_integer_tlv_encoder #(.VALUE_BYTES(VALUE_BYTES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_tag(req_tag),
      .req_value(req_value),
      .req_room(req_room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last),
      .rsp_error(rsp_error),
      .rsp_room_left(rsp_room_left)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int encoded_content_len(input logic op, input logic [63:0] value);
      logic [63:0] v;
      int          len;
      v = value << (64 - 8 * VALUE_BYTES);
      len = VALUE_BYTES;
      if (op == OP_UNSIGNED && v[63]) begin
         return VALUE_BYTES + 1;
      end
      while (len > 1 && (v[63:55] == '0 || v[63:55] == '1)) begin
         len--;
         v = v << 8;
      end
      return len;
   endfunction

   function automatic void predict_encoding(input logic op, input logic [TAG_W-1:0] tag,
                                            input logic [63:0] value,
                                            input logic [ROOM_W-1:0] room);
      logic [63:0]       v;
      logic [ROOM_W-1:0] left;
      logic              pad;
      int                clen;
      int                len;
      v = value << (64 - 8 * VALUE_BYTES);
      pad = (op == OP_UNSIGNED) && v[63];
      clen = encoded_content_len(op, value);
      len = clen - (pad ? 1 : 0);
      v = v << (8 * (VALUE_BYTES - len));
      if (int'(room) < 2 + clen) begin
         pending_bytes.push_back('{8'h00, 1'b1, 1'b1, room});
         return;
      end
      left = room - ROOM_W'(1);
      pending_bytes.push_back('{tag, 1'b0, 1'b0, left});
      left = left - ROOM_W'(1);
      pending_bytes.push_back('{BYTE_W'(clen), 1'b0, 1'b0, left});
      if (pad) begin
         left = left - ROOM_W'(1);
         pending_bytes.push_back('{8'h00, 1'b0, 1'b0, left});
      end
      for (int i = 0; i < len; i++) begin
         left = left - ROOM_W'(1);
         pending_bytes.push_back('{v[63:56], (i + 1 == len), 1'b0, left});
         v = v << 8;
      end
   endfunction

   task automatic send_request(input logic op, input logic [TAG_W-1:0] tag,
                               input logic [63:0] value, input logic [ROOM_W-1:0] room);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_tag    <= tag;
      req_value  <= value;
      req_room   <= room;
      do @(posedge clock); while (req_stall);
      predict_encoding(op, tag, value, room);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [ROOM_W-1:0] pick_room(input logic op, input logic [63:0] value);
      int clen;
      clen = encoded_content_len(op, value);
      case ($urandom_range(0, 9))
         0: return ROOM_W'($urandom_range(0, 1 + clen));
         1: return ROOM_W'(2 + clen);
         2: return ROOM_W'($urandom);
         3: return '1;
         default: return ROOM_W'($urandom_range(2 + clen, 2 + clen + 200));
      endcase
   endfunction

   function automatic logic [63:0] pick_value();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
         return raw;
      end
      return $signed(raw) >>> (8 * (8 - $urandom_range(1, 8)));
   endfunction

   task automatic test_extremes();
      send_request(OP_SIGNED,   8'h02, 64'd0, 16'd100);
      send_request(OP_SIGNED,   8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd100);
      send_request(OP_SIGNED,   8'h00, 64'd127, 16'd100);
      send_request(OP_SIGNED,   8'h02, 64'd128, 16'd100);
      send_request(OP_SIGNED,   8'h02, -64'sd128, 16'd100);
      send_request(OP_SIGNED,   8'h02, -64'sd129, 16'd100);
      send_request(OP_SIGNED,   8'h02, 64'd256, 16'd100);
      send_request(OP_SIGNED,   8'hA5, 64'h7FFF_FFFF_FFFF_FFFF, 16'd100);
      send_request(OP_SIGNED,   8'h5A, 64'h8000_0000_0000_0000, 16'd100);
      send_request(OP_UNSIGNED, 8'h02, 64'd0, 16'd100);
      send_request(OP_UNSIGNED, 8'h02, 64'h80, 16'd100);
      send_request(OP_UNSIGNED, 8'h02, 64'hFFFF_FFFF_FFFF_FFFF, 16'd100);
      send_request(OP_UNSIGNED, 8'h02, 64'h8000_0000_0000_0000, 16'd100);
      send_request(OP_UNSIGNED, 8'h02, 64'h7FFF_FFFF_FFFF_FFFF, 16'd100);
   endtask

   task automatic test_room_limits();
      send_request(OP_SIGNED,   8'h02, 64'd5, 16'd0);
      send_request(OP_SIGNED,   8'h02, 64'h1234, 16'd3);
      send_request(OP_SIGNED,   8'h02, 64'h1234, 16'd4);
      send_request(OP_UNSIGNED, 8'h02, 64'hFFFF_FFFF_FFFF_FFFF, 16'd10);
      send_request(OP_UNSIGNED, 8'h02, 64'hFFFF_FFFF_FFFF_FFFF, 16'd11);
      send_request(OP_SIGNED,   8'h02, 64'h0123_4567_89AB_CDEF, 16'hFFFF);
      idle_sender(3);
   endtask

   task automatic test_random();
      logic [63:0] value;
      logic        op;
      int          burst_left;
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            idle_sender($urandom_range(0, 6));
         end
         op = logic'($urandom_range(0, 1));
         value = pick_value();
         send_request(op, TAG_W'($urandom), value, pick_room(op, value));
         burst_left--;
      end
   endtask

   task automatic test_backpressure();
      logic [63:0] value;
      logic        op;
      holdoff_asked <= holdoff_asked + 1;
      for (int n = 0; n < 10; n++) begin
         op = logic'($urandom_range(0, 1));
         value = pick_value();
         send_request(op, TAG_W'($urandom), value, 16'hFFFF);
      end
      idle_sender(1);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holdoff_asked != holdoff_served) begin
         holdoff_served <= holdoff_asked;
         hold_left <= HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (run_left == 0) begin
            run_left <= $urandom_range(1, 16);
            run_stalls <= ($urandom_range(0, 2) == 0);
         end else begin
            run_left <= run_left - 1;
         end
         rsp_stall <= run_stalls && ($urandom_range(0, 1) == 0);
      end
   end

   always @(posedge clock) begin
      tlv_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected byte %h last %b error %b room_left %0d", $time,
                     rsp_out_byte, rsp_last, rsp_error, rsp_room_left);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_last !== want.last ||
                rsp_error !== want.error || rsp_room_left !== want.room_left) begin
               mismatches++;
               $display("%0t: expected byte %h last %b error %b room_left %0d", $time,
                        want.out_byte, want.last, want.error, want.room_left);
               $display("%0t: actual   byte %h last %b error %b room_left %0d", $time,
                        rsp_out_byte, rsp_last, rsp_error, rsp_room_left);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d bytes outstanding", $time, pending_bytes.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_room_limits();
      test_random();
      test_backpressure();
      idle_sender(0);
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
